### rtl/mecanum_wheel_mixer_defines.svh
// ----------------------------------------------------------------------------
// Mecanum wheel mixer assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH

// same-cycle implication, masked during reset
`define MWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define MWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define MWM_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Constants, polynomial coefficients and inter-stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int LIM_W          = 15;
    localparam logic [LIM_W-1:0] MAX_SPEED_RST = 15'd1500;

    // quarter-wave sine polynomial, Q30
    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [29:0] POLY_B = 30'd688904866;
    localparam logic [26:0] POLY_C = 27'd76016977;

    // wheel order: 0 front left, 1 back left, 2 front right, 3 back right
    localparam int NWHEEL = 4;

    typedef struct packed {
        logic        [15:0] heading;
        logic signed [15:0] trans_speed;
        logic signed [15:0] turn_rate;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] trans_speed;
        logic signed [15:0] turn_rate;
        logic signed [15:0] sin_q;
        logic signed [15:0] cos_q;
    } t_trig;

    typedef struct packed {
        logic [NWHEEL-1:0][31:0] num;
        logic [NWHEEL-1:0][15:0] lo;
        logic [NWHEEL-1:0]       neg;
        logic [16:0]             den;
        logic                    scaled;
    } t_mix;

    typedef struct packed {
        logic [NWHEEL-1:0][15:0] speed;
        logic                    scaled;
    } t_wheels;

endpackage

`default_nettype wire

### rtl/mwm_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Heading, translational speed and turn rate with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwm_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading;
    logic [15:0] trans_speed;
    logic [15:0] turn_rate;

    modport source (output valid, heading, trans_speed, turn_rate, input ready);
    modport sink   (input valid, heading, trans_speed, turn_rate, output ready);
endinterface

`default_nettype wire

### rtl/mwm_wheel_if.sv
// ----------------------------------------------------------------------------
// Wheel speed channel
// Four wheel speeds and the scaled flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwm_wheel_if;
    logic        valid;
    logic        ready;
    logic [15:0] front_left;
    logic [15:0] back_left;
    logic [15:0] front_right;
    logic [15:0] back_right;
    logic        scaled;

    modport source (output valid, front_left, back_left, front_right, back_right, scaled,
                    input ready);
    modport sink   (input valid, front_left, back_left, front_right, back_right, scaled,
                    output ready);
endinterface

`default_nettype wire

### rtl/mwm_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the speed limit register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwm_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] max_speed;

    modport source (output valid, max_speed, input ready);
    modport sink   (input valid, max_speed, output ready);
endinterface

`default_nettype wire

### rtl/mwm_sincos.sv
// ----------------------------------------------------------------------------
// Sine/cosine pipeline
// Four-stage Q1.15 sine and cosine of the heading by quarter-wave polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_sincos import mwm_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cmd  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_trig o_data
);

    localparam int NSTG = 4;
    localparam int PSHIFT = 24 - ANGLE_BITS;
    localparam logic [23:0] AMASK = 24'((64'd1 << ANGLE_BITS) - 64'd1);

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    // channel 0 is sine, channel 1 is cosine
    logic [1:0][30:0] w_x, w_x2;
    logic [1:0]       w_neg;
    logic [1:0][29:0] w_u;
    logic [1:0][30:0] w_w;
    logic [1:0][15:0] w_s;

    logic [1:0][30:0] r1_x, r1_x2;
    logic [1:0]       r1_neg;
    logic [15:0]      r1_sp, r1_om;
    logic [1:0][30:0] r2_x, r2_x2;
    logic [1:0][29:0] r2_u;
    logic [1:0]       r2_neg;
    logic [15:0]      r2_sp, r2_om;
    logic [1:0][30:0] r3_x, r3_w;
    logic [1:0]       r3_neg;
    logic [15:0]      r3_sp, r3_om;
    logic [1:0][15:0] r4_s;
    logic [15:0]      r4_sp, r4_om;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];

    always_comb begin
        logic [1:0][23:0] ph;
        logic [21:0]      f;
        logic [61:0]      xx;
        logic [57:0]      pt;
        logic [60:0]      pv;
        logic [61:0]      py;
        logic [30:0]      y;
        logic [16:0]      q;
        logic [15:0]      sat;
        ph[0] = 24'((({8'b0, i_data.heading}) & AMASK) << PSHIFT);
        ph[1] = ph[0] + 24'h400000;
        for (int c = 0; c < 2; c++) begin
            f = ph[c][21:0];
            w_x[c] = ph[c][22] ? {23'h400000 - {1'b0, f}, 8'b0} : {1'b0, f, 8'b0};
            w_neg[c] = ph[c][23];
            xx = 62'(w_x[c]) * 62'(w_x[c]);
            w_x2[c] = 31'(xx >> 30);
            pt = 58'(r1_x2[c]) * 58'(POLY_C);
            w_u[c] = POLY_B - {3'b0, 27'(pt >> 30)};
            pv = 61'(r2_x2[c]) * 61'(r2_u[c]);
            w_w[c] = POLY_A - {1'b0, 30'(pv >> 30)};
            py = 62'(r3_x[c]) * 62'(r3_w[c]);
            y = 31'(py >> 30);
            q = 17'(({1'b0, y} + 32'd16384) >> 15);
            sat = (q > 17'd32767) ? 16'd32767 : q[15:0];
            w_s[c] = r3_neg[c] ? 16'(-sat) : sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_x   <= w_x;
            r1_x2  <= w_x2;
            r1_neg <= w_neg;
            r1_sp  <= i_data.trans_speed;
            r1_om  <= i_data.turn_rate;
        end
        if (w_en[1]) begin
            r2_x   <= r1_x;
            r2_x2  <= r1_x2;
            r2_u   <= w_u;
            r2_neg <= r1_neg;
            r2_sp  <= r1_sp;
            r2_om  <= r1_om;
        end
        if (w_en[2]) begin
            r3_x   <= r2_x;
            r3_w   <= w_w;
            r3_neg <= r2_neg;
            r3_sp  <= r2_sp;
            r3_om  <= r2_om;
        end
        if (w_en[3]) begin
            r4_s  <= w_s;
            r4_sp <= r3_sp;
            r4_om <= r3_om;
        end
    end

    assign o_data.trans_speed = r4_sp;
    assign o_data.turn_rate   = r4_om;
    assign o_data.sin_q       = r4_s[0];
    assign o_data.cos_q       = r4_s[1];

endmodule

`default_nettype wire

### rtl/mwm_mix.sv
// ----------------------------------------------------------------------------
// Wheel mixer pipeline
// Velocity products, wheel sums, largest magnitude and scale numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_mix import mwm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LIM_W-1:0] i_max_speed,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_trig            i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_mix             o_data
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    logic signed [31:0] r1_vx, r1_vy;
    logic signed [15:0] r1_om;
    logic [NWHEEL-1:0][17:0] r2_wh;
    logic [NWHEEL-1:0][16:0] r3_abs;
    logic [NWHEEL-1:0][15:0] r3_lo;
    logic [NWHEEL-1:0]       r3_neg;
    logic [16:0]             r3_big;
    logic                    r3_sc;
    t_mix                    r4;

    logic [NWHEEL-1:0][17:0] w_wh;
    logic [NWHEEL-1:0][16:0] w_abs;
    logic [16:0]             w_big;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];

    // wheel sums in Q15, truncated toward zero
    always_comb begin
        logic signed [33:0] vx, vy, wq, adj;
        logic signed [33:0] s [NWHEEL];
        vx = 34'(r1_vx);
        vy = 34'(r1_vy);
        wq = 34'(r1_om) <<< 15;
        s[0] = vx + vy + wq;
        s[1] = vx - vy + wq;
        s[2] = vx - vy - wq;
        s[3] = vx + vy - wq;
        for (int i = 0; i < NWHEEL; i++) begin
            adj = s[i] + (s[i][33] ? 34'sd32767 : 34'sd0);
            w_wh[i] = 18'(adj >>> 15);
        end
    end

    // magnitudes and a two-level max tree
    always_comb begin
        logic signed [17:0] wh;
        logic [16:0]        m01, m23;
        for (int i = 0; i < NWHEEL; i++) begin
            wh = $signed(r2_wh[i]);
            w_abs[i] = wh[17] ? 17'(-wh) : 17'(wh);
        end
        m01 = (w_abs[0] > w_abs[1]) ? w_abs[0] : w_abs[1];
        m23 = (w_abs[2] > w_abs[3]) ? w_abs[2] : w_abs[3];
        w_big = (m01 > m23) ? m01 : m23;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_vx <= 32'(i_data.trans_speed) * 32'(i_data.cos_q);
            r1_vy <= 32'(i_data.trans_speed) * 32'(i_data.sin_q);
            r1_om <= i_data.turn_rate;
        end
        if (w_en[1]) begin
            r2_wh <= w_wh;
        end
        if (w_en[2]) begin
            r3_abs <= w_abs;
            for (int i = 0; i < NWHEEL; i++) begin
                r3_lo[i]  <= r2_wh[i][15:0];
                r3_neg[i] <= r2_wh[i][17];
            end
            r3_big <= w_big;
            r3_sc  <= w_big > {2'b0, i_max_speed};
        end
        if (w_en[3]) begin
            for (int i = 0; i < NWHEEL; i++) begin
                r4.num[i] <= 32'(r3_abs[i]) * 32'(i_max_speed);
            end
            r4.lo     <= r3_lo;
            r4.neg    <= r3_neg;
            r4.den    <= r3_big;
            r4.scaled <= r3_sc;
        end
    end

    assign o_data = r4;

endmodule

`default_nettype wire

### rtl/mwm_scale.sv
// ----------------------------------------------------------------------------
// Proportional scaler
// Restoring divider, one quotient bit per stage, then sign and select.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_scale import mwm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_mix    i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_wheels o_data
);

    localparam int QBITS = LIM_W;
    localparam int NSTG  = QBITS + 1;

    typedef struct packed {
        logic [NWHEEL-1:0][31:0]      rem;
        logic [NWHEEL-1:0][QBITS-1:0] quo;
        logic [NWHEEL-1:0][15:0]      lo;
        logic [NWHEEL-1:0]            neg;
        logic [16:0]                  den;
        logic                         scaled;
    } t_div_stage;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;
    t_div_stage      w_src [QBITS];
    t_div_stage      w_nxt [QBITS];
    t_div_stage      r_st  [QBITS];
    t_wheels         w_out;
    t_wheels         r_out;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];

    always_comb begin
        w_src[0].rem    = i_data.num;
        w_src[0].quo    = '0;
        w_src[0].lo     = i_data.lo;
        w_src[0].neg    = i_data.neg;
        w_src[0].den    = i_data.den;
        w_src[0].scaled = i_data.scaled;
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_div
        localparam int SH = QBITS - 1 - j;

        if (j > 0) begin : g_link
            assign w_src[j] = r_st[j-1];
        end

        always_comb begin
            logic [31:0] dsh;
            w_nxt[j] = w_src[j];
            dsh = {15'b0, w_src[j].den} << SH;
            for (int i = 0; i < NWHEEL; i++) begin
                if (w_src[j].rem[i] >= dsh) begin
                    w_nxt[j].rem[i]     = w_src[j].rem[i] - dsh;
                    w_nxt[j].quo[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j]) r_st[j] <= w_nxt[j];
        end
    end

    always_comb begin
        logic [15:0] mag;
        w_out.scaled = r_st[QBITS-1].scaled;
        for (int i = 0; i < NWHEEL; i++) begin
            mag = 16'(r_st[QBITS-1].quo[i]);
            if (r_st[QBITS-1].scaled) begin
                w_out.speed[i] = r_st[QBITS-1].neg[i] ? 16'(-mag) : mag;
            end else begin
                w_out.speed[i] = r_st[QBITS-1].lo[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) r_out <= w_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

### rtl/mecanum_wheel_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer
// Inverse kinematics of a four-wheel mecanum base with proportional limiting.
// ----------------------------------------------------------------------------
// i_cmd carries heading (binary angle), trans_speed and turn_rate; o_wheel
// returns front_left, back_left, front_right, back_right and scaled. Both
// use valid/ready; an item moves when both are high at a clock edge.
// i_cfg writes max_speed; it is always ready and should be written while
// no item is in flight.
// The pipeline runs through the sine/cosine stages, the mixing and largest
// magnitude stages, the restoring divider (one quotient bit per stage) and
// one output register. Throughput is one item per cycle while nothing stalls.
// Each stage holds its own valid bit and advances when the stage after it
// is empty or moving, so a stalled receiver freezes only the full stages
// and bubbles close up; i_cmd.ready drops only when every stage is full.
// Synchronous reset empties the pipeline and sets max_speed to 1500.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_mixer import mwm_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mwm_cmd_if.sink           i_cmd,
    mwm_wheel_if.source       o_wheel,
    mwm_cfg_if.sink           i_cfg
);

    logic [LIM_W-1:0] r_max_speed;

    t_cmd    w_cmd;
    t_trig   w_trig;
    t_mix    w_mix;
    t_wheels w_out;
    logic    w_trig_v, w_trig_r, w_mix_v, w_mix_r;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RST;
        end else if (i_cfg.valid) begin
            r_max_speed <= i_cfg.max_speed;
        end
    end

    assign w_cmd.heading     = i_cmd.heading;
    assign w_cmd.trans_speed = i_cmd.trans_speed;
    assign w_cmd.turn_rate   = i_cmd.turn_rate;

    mwm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_data  (w_cmd),
        .o_valid (w_trig_v),
        .i_ready (w_trig_r),
        .o_data  (w_trig)
    );

    mwm_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_speed (r_max_speed),
        .i_valid     (w_trig_v),
        .o_ready     (w_trig_r),
        .i_data      (w_trig),
        .o_valid     (w_mix_v),
        .i_ready     (w_mix_r),
        .o_data      (w_mix)
    );

    mwm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mix_v),
        .o_ready (w_mix_r),
        .i_data  (w_mix),
        .o_valid (o_wheel.valid),
        .i_ready (o_wheel.ready),
        .o_data  (w_out)
    );

    assign o_wheel.front_left  = w_out.speed[0];
    assign o_wheel.back_left   = w_out.speed[1];
    assign o_wheel.front_right = w_out.speed[2];
    assign o_wheel.back_right  = w_out.speed[3];
    assign o_wheel.scaled      = w_out.scaled;

endmodule

`default_nettype wire

### rtl/mwm_checker.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer port checker
// Watches the top-level ports for output range, hold and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mecanum_wheel_mixer_defines.svh"

module mwm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_fl,
    input logic [15:0] i_bl,
    input logic [15:0] i_fr,
    input logic [15:0] i_br,
    input logic        i_scaled,
    input logic        i_cfg_ready
);

    `MWM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_fl) && $stable(i_br) && $stable(i_scaled), "stalled item changed")
    `MWM_ASSERT_NOW(a_wheel_range, i_out_valid, i_fl != 16'h8000 && i_bl != 16'h8000 && i_fr != 16'h8000 && i_br != 16'h8000, "wheel speed out of range")
    `MWM_ASSERT_RST(a_rst_empty, !i_rst_n, !i_out_valid, "item left after reset")
    `MWM_ASSERT_RST(a_rst_cfg, !i_rst_n, i_cfg_ready, "config port not ready after reset")

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_wheel.valid),
    .i_out_ready (o_wheel.ready),
    .i_fl        (o_wheel.front_left),
    .i_bl        (o_wheel.back_left),
    .i_fr        (o_wheel.front_right),
    .i_br        (o_wheel.back_right),
    .i_scaled    (o_wheel.scaled),
    .i_cfg_ready (i_cfg.ready)
);

`default_nettype wire

### tb/mwm_tb_if.sv
// ----------------------------------------------------------------------------
// Mixer testbench types
// Expected wheel set as kept in the scoreboard queue.
// ----------------------------------------------------------------------------
package mwm_tb_pkg;

    typedef struct packed {
        logic [15:0] fl;
        logic [15:0] bl;
        logic [15:0] fr;
        logic [15:0] br;
        logic        scaled;
    } t_wheel_set;

endpackage

### tb/mecanum_wheel_mixer_tb.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer testbench
// Drives commands with bursty valid and a stalling receiver, predicts each
// wheel set with a local fixed-point model and compares field by field.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_tb;
    import mwm_pkg::*;
    import mwm_tb_pkg::*;

    localparam int LATENCY = 24;
    localparam longint LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    mwm_cmd_if   cmd_ch();
    mwm_wheel_if whl_ch();
    mwm_cfg_if   cfg_ch();

    mecanum_wheel_mixer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_wheel (whl_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    t_cmd       cmd_queue[$];
    t_wheel_set wheel_expect[$];
    logic [14:0] speed_limit;
    int         errors;
    longint     cycles;
    int         hold_off;
    bit         long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // quarter-wave polynomial, x in Q30 over [0, 1.0], result in Q15
    function automatic longint quarter_sin(longint unsigned x);
        longint unsigned a, b, c, x2, t, v, w, y, q;
        a = 64'd1686629713;
        b = 2 * a - 64'd2684354560;
        c = a - 64'd1610612736;
        x2 = (x * x) >> 30;
        t = (x2 * c) >> 30;
        v = (x2 * (b - t)) >> 30;
        w = a - v;
        y = (x * w) >> 30;
        q = (y + (64'd1 << 14)) >> 15;
        if (q > 32767) q = 32767;
        return longint'(q);
    endfunction

    function automatic longint phase_sin(logic [23:0] p);
        logic [1:0] quad;
        longint unsigned f, x;
        longint s;
        quad = p[23:22];
        f = 64'(p[21:0]);
        x = quad[0] ? ((64'd1 << 22) - f) << 8 : f << 8;
        if (x > (64'd1 << 30)) x = 64'd1 << 30;
        s = quarter_sin(x);
        return quad[1] ? -s : s;
    endfunction

    function automatic t_wheel_set mix_wheels(t_cmd cmd, logic [14:0] lim);
        logic [23:0] p;
        longint sp, om, cq, sq, vx, vy, wq, largest, mag;
        longint wh[4];
        t_wheel_set r;
        p = {cmd.heading, 8'd0};
        sp = longint'(cmd.trans_speed);
        om = longint'(cmd.turn_rate);
        cq = phase_sin(p + 24'h400000);
        sq = phase_sin(p);
        vx = sp * cq;
        vy = sp * sq;
        wq = om * 32768;
        wh[0] = (vx + vy + wq) / 32768;
        wh[1] = (vx - vy + wq) / 32768;
        wh[2] = (vx - vy - wq) / 32768;
        wh[3] = (vx + vy - wq) / 32768;
        largest = 0;
        foreach (wh[i]) begin
            mag = wh[i] < 0 ? -wh[i] : wh[i];
            if (mag > largest) largest = mag;
        end
        r.scaled = largest > longint'(lim);
        if (r.scaled) begin
            foreach (wh[i]) wh[i] = (wh[i] * longint'(lim)) / largest;
        end
        r.fl = wh[0][15:0];
        r.bl = wh[1][15:0];
        r.fr = wh[2][15:0];
        r.br = wh[3][15:0];
        return r;
    endfunction

    // command driver: bursts of random length, random gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                wheel_expect.push_back(mix_wheels(cmd_queue.pop_front(), speed_limit));
            end
            if (!(cmd_ch.valid && !cmd_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    cmd_ch.valid       <= 1'b1;
                    cmd_ch.heading     <= cmd_queue[0].heading;
                    cmd_ch.trans_speed <= cmd_queue[0].trans_speed;
                    cmd_ch.turn_rate   <= cmd_queue[0].turn_rate;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(40);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                    end
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // wheel monitor; receiver stalls on its own pattern, long hold on request
    logic [7:0] stall_pat;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (!i_rst_n) begin
            whl_ch.ready <= 1'b0;
            stall_pat = 8'b1011_0111;
            hold_off = 0;
        end else begin
            if (whl_ch.valid && whl_ch.ready) begin
                if (wheel_expect.size() == 0) begin
                    $error("wheel set with nothing expected");
                    errors++;
                end else begin
                    t_wheel_set e;
                    e = wheel_expect.pop_front();
                    if (whl_ch.front_left !== e.fl) begin
                        $error("front_left exp %0d got %0d", $signed(e.fl),
                               $signed(whl_ch.front_left));
                        errors++;
                    end
                    if (whl_ch.back_left !== e.bl) begin
                        $error("back_left exp %0d got %0d", $signed(e.bl),
                               $signed(whl_ch.back_left));
                        errors++;
                    end
                    if (whl_ch.front_right !== e.fr) begin
                        $error("front_right exp %0d got %0d", $signed(e.fr),
                               $signed(whl_ch.front_right));
                        errors++;
                    end
                    if (whl_ch.back_right !== e.br) begin
                        $error("back_right exp %0d got %0d", $signed(e.br),
                               $signed(whl_ch.back_right));
                        errors++;
                    end
                    if (whl_ch.scaled !== e.scaled) begin
                        $error("scaled exp %0d got %0d", e.scaled, whl_ch.scaled);
                        errors++;
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_off = 200;
            end
            if (hold_off > 0) begin
                hold_off--;
                whl_ch.ready <= 1'b0;
            end else begin
                stall_pat = {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ stall_pat[4]
                             ^ stall_pat[3]};
                if ($urandom_range(15) == 0) stall_pat = 8'($urandom);
                whl_ch.ready <= stall_pat[0] | stall_pat[1] | (cycles[9:8] == 2'b00);
            end
        end
    end

    task automatic write_limit(logic [14:0] v);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.max_speed <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        speed_limit = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || cmd_ch.valid || wheel_expect.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.heading = 16'($urandom);
        case ($urandom_range(5))
            0: c.trans_speed = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1: c.trans_speed = $signed(16'($urandom_range(2000))) - 16'sd1000;
            default: c.trans_speed = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0: c.turn_rate = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1: c.turn_rate = $signed(16'($urandom_range(2000))) - 16'sd1000;
            default: c.turn_rate = 16'($urandom);
        endcase
        if ($urandom_range(7) == 0) c.heading = 16'($urandom_range(3)) << 14;
        return c;
    endfunction

    logic [14:0] limits[6] = '{15'd1500, 15'd1, 15'd32767, 15'd0, 15'd100, 15'd20000};
    logic [15:0] heads[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff,
                              16'h2000, 16'h0001, 16'h3fff};

    initial begin
        t_cmd c;
        errors = 0;
        cycles = 0;
        long_hold_req = 1'b0;
        speed_limit = MAX_SPEED_RST;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.heading = '0;
        cmd_ch.trans_speed = '0;
        cmd_ch.turn_rate = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.max_speed = '0;
        whl_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unit angles, extremes, all-zero set at reset limit
        foreach (heads[i]) begin
            c.heading = heads[i];
            c.trans_speed = (i % 2) ? 16'sh8000 : 16'sh7fff;
            c.turn_rate = (i % 3 == 0) ? 16'sh8000 : 16'sh7fff;
            cmd_queue.push_back(c);
        end
        c = '0;
        cmd_queue.push_back(c);
        c.trans_speed = 16'sd1000;
        cmd_queue.push_back(c);
        c.trans_speed = 16'shffff;
        c.turn_rate = 16'sh0001;
        c.heading = 16'h5555;
        cmd_queue.push_back(c);
        wait_drained();

        foreach (limits[k]) begin
            write_limit(limits[k]);
            if (k == 0) begin
                c = '0;
                cmd_queue.push_back(c);
                c.turn_rate = 16'sd5;
                cmd_queue.push_back(c);
            end
            if (k == 2) long_hold_req = 1'b1;
            repeat (115) cmd_queue.push_back(rand_cmd());
            wait_drained();
        end
        write_limit(15'($urandom_range(32767)));
        repeat (20) cmd_queue.push_back(rand_cmd());
        wait_drained();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
